### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### rtl/spl_pkg.sv
// ---------------------------------------------------------------------------
// spl_pkg
// types and constants shared by the segment position lookup modules
// ---------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 1024;

    // item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_HICHK,
        S_LOOP,
        S_CMP,
        S_FETCH,
        S_CALC,
        S_DONE
    } state_t;

    // address source for the primary offset read port
    typedef enum logic [1:0] {
        RD_HI,
        RD_MID,
        RD_SEG
    } rd_sel_t;

    // source of the found segment index
    typedef enum logic [1:0] {
        SEG_LO,
        SEG_HI,
        SEG_MIDM1
    } seg_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     write_entry;
        logic     load_query;
        rd_sel_t  rd_sel;
        logic     set_lo_mid;
        logic     set_hi_mid;
        logic     seg_load;
        seg_sel_t seg_sel;
        logic     calc;
        logic     load_out;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic lo_ge_hi;
        logic a_le_pos;
        logic b_gt_pos;
        logic span_gt1;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/spl_ctrl.sv
// ---------------------------------------------------------------------------
// spl_ctrl
// sequencer for table writes, the predecessor search and the result step
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spl_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  mode,
    input  wire spl_pkg::ctrl_status_t status,
    output spl_pkg::ctrl_cmd_t         cmd
);
    import spl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_SEG;
        cmd.seg_sel = SEG_LO;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (mode == MODE_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = S_SETUP;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            S_SETUP:
            begin
                if (status.lo_ge_hi)
                begin
                    cmd.seg_load = 1'b1;
                    cmd.seg_sel  = SEG_LO;
                    state_next   = S_FETCH;
                end
                else
                begin
                    cmd.rd_sel = RD_HI;
                    state_next = S_HICHK;
                end
            end
            S_HICHK:
            begin
                if (status.a_le_pos)
                begin
                    cmd.seg_load = 1'b1;
                    cmd.seg_sel  = SEG_HI;
                    state_next   = S_FETCH;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (status.span_gt1)
                begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.seg_load = 1'b1;
                    cmd.seg_sel  = SEG_LO;
                    state_next   = S_FETCH;
                end
            end
            S_CMP:
            begin
                priority if (status.a_le_pos)
                begin
                    cmd.set_lo_mid = 1'b1;
                    state_next     = S_LOOP;
                end
                else if (status.b_gt_pos)
                begin
                    cmd.set_hi_mid = 1'b1;
                    state_next     = S_LOOP;
                end
                else
                begin
                    cmd.seg_load = 1'b1;
                    cmd.seg_sel  = SEG_MIDM1;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.rd_sel = RD_SEG;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a query keeps the input side closed on the following cycle
    `ASSERT_NEXT(a_query_closes_input, in_valid && !in_stall && mode == MODE_QUERY, in_stall)
    // the search interval never collapses while a midpoint is compared
    `ASSERT_IMPLIES(a_cmp_open_interval, state_reg == S_CMP, !status.lo_ge_hi)

endmodule

`default_nettype wire

### rtl/spl_datapath.sv
// ---------------------------------------------------------------------------
// spl_datapath
// segment table memories, search bounds, position arithmetic, output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spl_datapath #(
    parameter int TABLE_ENTRIES = spl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire spl_pkg::ctrl_cmd_t    cmd,
    output spl_pkg::ctrl_status_t      status,
    input  wire logic [9:0]            entry_index,
    input  wire logic [31:0]           entry_offset,
    input  wire logic [31:0]           entry_start,
    input  wire logic [31:0]           entry_length,
    input  wire logic [9:0]            first_entry,
    input  wire logic [10:0]           entry_count,
    input  wire logic [31:0]           text_length,
    input  wire logic [31:0]           index_position,
    input  wire logic [31:0]           hit_length,
    input  wire logic                  reverse_strand,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [9:0]                 segment_index,
    output logic [31:0]                segment_position,
    output logic                       out_of_range
);
    import spl_pkg::*;

    localparam int          IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [31:0] LAST_IDX = 32'(TABLE_ENTRIES - 1);

    // table memories
    logic [31:0] offset_mem [TABLE_ENTRIES];
    logic [31:0] start_mem  [TABLE_ENTRIES];
    logic [31:0] length_mem [TABLE_ENTRIES];

    logic [IDX_W-1:0] wr_addr;
    logic             wr_in_table;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic [31:0]      rd_a_reg;
    logic [31:0]      rd_b_reg;
    logic [31:0]      start_rd_reg;
    logic [31:0]      length_rd_reg;

    // query registers
    logic [IDX_W-1:0] lo_reg;
    logic [IDX_W-1:0] hi_reg;
    logic [IDX_W-1:0] seg_reg;
    logic [31:0]      pos_reg;
    logic [31:0]      hlen_reg;
    logic             rev_reg;
    logic [31:0]      spos_reg;
    logic [32:0]      rhs_reg;

    // output register
    logic             out_valid_reg;
    logic [9:0]       seg_out_reg;
    logic [31:0]      spos_out_reg;
    logic             oor_out_reg;

    // slice setup
    logic [10:0]      count_eff;
    logic [IDX_W-1:0] first_sat;
    logic [31:0]      last_sum;
    logic [IDX_W-1:0] last_sat;
    logic [31:0]      pos_in;

    // search arithmetic
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] mid_m1;
    logic [IDX_W-1:0] span;

    // result arithmetic
    logic [31:0]      spos_fwd;
    logic [31:0]      spos_calc;
    logic [32:0]      lhs;

    // write address and range check
    assign wr_addr     = IDX_W'(entry_index);
    assign wr_in_table = (32'(entry_index) < 32'(TABLE_ENTRIES));

    // saturated slice bounds and mirrored position
    always_comb
    begin
        count_eff = (entry_count == 11'd0) ? 11'd1 : entry_count;
        first_sat = (32'(first_entry) > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : IDX_W'(first_entry);
        last_sum  = 32'(first_sat) + 32'(count_eff) - 32'd1;
        last_sat  = (last_sum > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : last_sum[IDX_W-1:0];
        pos_in    = reverse_strand ? (text_length - index_position - 32'd2) : index_position;
    end

    // midpoint of the open interval
    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + {{IDX_W{1'b0}}, 1'b1};
        mid     = mid_sum[IDX_W:1];
        mid_m1  = mid - IDX_W'(1);
        span    = hi_reg - lo_reg;
    end

    // read address selection
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HI:   rd_addr_a = hi_reg;
            RD_MID:  rd_addr_a = mid;
            RD_SEG:  rd_addr_a = seg_reg;
            default: rd_addr_a = seg_reg;
        endcase
        rd_addr_b = mid_m1;
    end

    // memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_in_table)
        begin
            offset_mem[wr_addr] <= entry_offset;
            start_mem[wr_addr]  <= entry_start;
            length_mem[wr_addr] <= entry_length;
        end
        rd_a_reg      <= offset_mem[rd_addr_a];
        rd_b_reg      <= offset_mem[rd_addr_b];
        start_rd_reg  <= start_mem[rd_addr_a];
        length_rd_reg <= length_mem[rd_addr_a];
    end

    // search bounds and query fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            lo_reg   <= first_sat;
            hi_reg   <= last_sat;
            pos_reg  <= pos_in;
            hlen_reg <= hit_length;
            rev_reg  <= reverse_strand;
        end
        else if (cmd.set_lo_mid)
        begin
            lo_reg <= mid;
        end
        else if (cmd.set_hi_mid)
        begin
            hi_reg <= mid;
        end
        if (cmd.seg_load)
        begin
            unique case (cmd.seg_sel)
                SEG_LO:    seg_reg <= lo_reg;
                SEG_HI:    seg_reg <= hi_reg;
                SEG_MIDM1: seg_reg <= mid_m1;
                default:   seg_reg <= lo_reg;
            endcase
        end
    end

    // position inside the segment and segment end
    always_comb
    begin
        spos_fwd  = pos_reg - rd_a_reg + 32'd1;
        spos_calc = rev_reg ? (length_rd_reg - spos_fwd + 32'd1) : spos_fwd;
        lhs       = {1'b0, spos_reg} + {1'b0, hlen_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            spos_reg <= spos_calc;
            rhs_reg  <= {1'b0, start_rd_reg} + {1'b0, length_rd_reg};
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            seg_out_reg  <= 10'(seg_reg);
            spos_out_reg <= spos_reg;
            oor_out_reg  <= (lhs > rhs_reg);
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // status to controller
    always_comb
    begin
        status.lo_ge_hi = (lo_reg >= hi_reg);
        status.a_le_pos = (rd_a_reg <= pos_reg);
        status.b_gt_pos = (rd_b_reg > pos_reg);
        status.span_gt1 = (span > IDX_W'(1));
        status.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign segment_index    = seg_out_reg;
    assign segment_position = spos_out_reg;
    assign out_of_range     = oor_out_reg;

    // a result appears only when the controller loads one
    `ASSERT_IMPLIES(a_out_rise_from_load, $rose(out_valid_reg), $past(cmd.load_out))

endmodule

`default_nettype wire

### rtl/segment_position_lookup.sv
// ---------------------------------------------------------------------------
// segment_position_lookup
// maps a hit position in an index block to a segment and a position in it
// ---------------------------------------------------------------------------
// Write items (mode 0) fill one table entry. A query item (mode 1) runs a
// predecessor binary search over its slice of the table; each search step
// has a read state and a compare state because the offset memory has
// registered reads (midpoint and its neighbor are read together on two
// ports). A query goes through setup, a check of the last slice entry and
// the search loop (both skipped for a one-entry slice), a fetch of the
// found entry and the result calculation, then waits for the output
// register to free up. One item is in work at a time; the result sits in
// an output register, so the next item is taken while the last result waits.
// The table has no reset: a query must only reach entries that were written.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_position_lookup #(
    parameter int TABLE_ENTRIES = spl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [9:0]  entry_index,
    input  wire logic [31:0] entry_offset,
    input  wire logic [31:0] entry_start,
    input  wire logic [31:0] entry_length,
    input  wire logic [9:0]  first_entry,
    input  wire logic [10:0] entry_count,
    input  wire logic [31:0] text_length,
    input  wire logic [31:0] index_position,
    input  wire logic [31:0] hit_length,
    input  wire logic        reverse_strand,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       segment_index,
    output logic [31:0]      segment_position,
    output logic             out_of_range
);
    import spl_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencer
    spl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    // table and arithmetic
    spl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .entry_index      (entry_index),
        .entry_offset     (entry_offset),
        .entry_start      (entry_start),
        .entry_length     (entry_length),
        .first_entry      (first_entry),
        .entry_count      (entry_count),
        .text_length      (text_length),
        .index_position   (index_position),
        .hit_length       (hit_length),
        .reverse_strand   (reverse_strand),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .segment_index    (segment_index),
        .segment_position (segment_position),
        .out_of_range     (out_of_range)
    );

endmodule

`default_nettype wire
